[sv/ettt_pkg.sv]
// Shared types, constants and the hash helper function of the target track table.
`timescale 1ns / 1ps
package ettt_pkg;

  localparam int unsigned MaxTargets = 16;
  localparam int unsigned SlotW      = $clog2(MaxTargets);
  localparam int unsigned CountW     = $clog2(MaxTargets + 1);
  localparam int unsigned CfgAddrW   = 4;

  // Register byte addresses
  localparam logic [CfgAddrW-1:0] RegGain      = 4'h0;
  localparam logic [CfgAddrW-1:0] RegMissLimit = 4'h4;
  localparam logic [CfgAddrW-1:0] RegThreshold = 4'h8;
  localparam logic [CfgAddrW-1:0] RegFade      = 4'hC;

  localparam logic [15:0] GainReset      = 16'd9830;
  localparam logic [7:0]  MissLimitReset = 8'd25;
  localparam logic [15:0] ThresholdReset = 16'd0;
  localparam logic [15:0] FadeReset      = 16'd45875;
  localparam logic [31:0] HashSeed       = 32'd5381;

  typedef enum logic [1:0] {
    OpBegin  = 2'd0,
    OpAdd    = 2'd1,
    OpUpdate = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StAccepted  = 2'd0,
    StFrameFull = 2'd1,
    StTableFull = 2'd2
  } status_e;

  // Classified command handed from front to back
  typedef struct packed {
    op_e         op;
    logic [31:0] hash;
    logic [15:0] bearing;
    logic [15:0] distance;
    logic [15:0] confidence;
    logic [15:0] color;
    logic [15:0] heading;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    status_e     status;
    logic [3:0]  slot;
    logic        slot_valid;
    logic        active;
    logic [15:0] view_angle;
    logic [15:0] view_range;
    logic [15:0] confidence_out;
    logic [15:0] color_out;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [7:0]  miss_limit;
    logic [15:0] threshold;
    logic [15:0] fade;
  } cfg_t;

  // One djb2-xor round
  function automatic logic [31:0] hash_step(logic [31:0] h, logic [7:0] b);
    hash_step = ((h << 5) + h) ^ {24'd0, b};
  endfunction

endpackage

[sv/ettt_front.sv]
// Front end: accepts items, hashes the six address bytes of an add, queues commands.
`timescale 1ns / 1ps
module ettt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  output logic           s_tready_o,
  input  logic [127:0]   s_tdata_i,
  input  logic [1:0]     s_tuser_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output ettt_pkg::cmd_t q_cmd_o
);
  import ettt_pkg::*;

  typedef enum logic [1:0] {FrIdle, FrHash, FrPush} fr_state_e;

  fr_state_e   state_q;
  logic [2:0]  byte_q;
  logic [47:0] mac_q;
  cmd_t        cmd_q;
  cmd_t        push_cmd;
  logic [31:0] hash_nx;
  logic [7:0]  cur_byte;

  // Two-entry command queue
  cmd_t        fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign s_tready_o = (state_q == FrIdle);
  assign cur_byte   = mac_q[47:40];
  assign hash_nx    = hash_step(cmd_q.hash, cur_byte);
  assign push       = (state_q == FrPush) && (cnt_q != 2'd2);
  assign pop        = q_valid_o && q_ready_i;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = fifo_q[rd_ptr_q];

  // Hash sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      byte_q  <= '0;
    end else begin
      unique case (state_q)
        FrIdle: begin
          if (s_tvalid_i) begin
            state_q <= (op_e'(s_tuser_i) == OpAdd) ? FrHash : FrPush;
            byte_q  <= '0;
          end
        end
        FrHash: begin
          byte_q <= byte_q + 3'd1;
          if (byte_q == 3'd5) state_q <= FrPush;
        end
        FrPush: begin
          if (push) state_q <= FrIdle;
        end
        default: state_q <= FrIdle;
      endcase
    end
  end

  // Payload capture and hash rounds
  always_ff @(posedge clk_i) begin
    if (state_q == FrIdle && s_tvalid_i) begin
      cmd_q.op         <= op_e'(s_tuser_i);
      mac_q            <= s_tdata_i[47:0];
      cmd_q.bearing    <= s_tdata_i[63:48];
      cmd_q.distance   <= s_tdata_i[79:64];
      cmd_q.confidence <= s_tdata_i[95:80];
      cmd_q.color      <= s_tdata_i[111:96];
      cmd_q.heading    <= s_tdata_i[127:112];
      cmd_q.hash       <= HashSeed;
    end else if (state_q == FrHash) begin
      cmd_q.hash <= hash_nx;
      mac_q      <= {mac_q[39:0], 8'd0};
    end
  end

  // Queued command; a zero hash becomes 1
  always_comb begin
    push_cmd      = cmd_q;
    push_cmd.hash = (cmd_q.hash == 32'd0) ? 32'd1 : cmd_q.hash;
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= push_cmd;
  end

endmodule

[sv/ettt_back.sv]
// Back end: slot table, smoothing, aging and per-slot reports.
`timescale 1ns / 1ps
module ettt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ettt_pkg::cfg_t cfg_i,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  ettt_pkg::cmd_t q_cmd_i,
  output logic           r_valid_o,
  input  logic           r_ready_i,
  output ettt_pkg::res_t r_res_o
);
  import ettt_pkg::*;

  typedef enum logic [2:0] {
    BkIdle, BkSearch, BkMul, BkWrite, BkUpd, BkUpdMul, BkEmit, BkOut
  } bk_state_e;

  bk_state_e state_q;
  cmd_t      cmd_q;

  logic [MaxTargets-1:0] occ_q, act_q, seen_q;
  logic [31:0]           ident_q [MaxTargets];
  logic [7:0]            miss_q  [MaxTargets];
  logic [15:0]           brg_q   [MaxTargets];
  logic [15:0]           dst_q   [MaxTargets];
  logic [15:0]           conf_q  [MaxTargets];
  logic [15:0]           col_q   [MaxTargets];
  logic [CountW-1:0]     frame_q, hw_q;

  logic [SlotW-1:0] idx_q;
  logic [CountW-1:0] scan_q;
  logic             hit_q, free_q;
  logic [SlotW-1:0] hit_idx_q, free_idx_q;
  logic             known_q;
  res_t             res_q;
  logic             r_valid_q;
  logic             last_slot_q;

  // Multiply products
  logic signed [17:0] db_q, dd_q;
  logic signed [34:0] pb_q, pd_q;
  logic [31:0]        pc_q;

  logic [SlotW-1:0]   scan_idx;
  logic signed [17:0] diff_b, diff_d;
  logic signed [18:0] step_b, step_d;
  logic signed [18:0] nd;
  logic [15:0]        nb, nd_sat, cnf_f;
  logic [7:0]         miss_inc;

  // Pack one result transfer
  function automatic res_t make_res(logic kind, status_e st, logic [3:0] slot,
                                    logic valid, logic act, logic [15:0] angle,
                                    logic [15:0] radius, logic [15:0] conf,
                                    logic [15:0] color, logic last);
    res_t r;
    r.kind           = kind;
    r.status         = st;
    r.slot           = slot;
    r.slot_valid     = valid;
    r.active         = act;
    r.view_angle     = angle;
    r.view_range     = radius;
    r.confidence_out = conf;
    r.color_out      = color;
    r.last           = last;
    return r;
  endfunction

  assign scan_idx  = scan_q[SlotW-1:0];
  assign q_ready_o = (state_q == BkIdle) && !r_valid_q;
  assign r_valid_o = r_valid_q;
  assign r_res_o   = res_q;

  // Signed shortest turn and linear differences
  always_comb begin
    diff_b = $signed({2'b00, cmd_q.bearing}) - $signed({2'b00, brg_q[idx_q]});
    if (diff_b > 18'sd32768)       diff_b = diff_b - 18'sd65536;
    else if (diff_b < -18'sd32768) diff_b = diff_b + 18'sd65536;
    diff_d = $signed({2'b00, cmd_q.distance}) - $signed({2'b00, dst_q[idx_q]});
  end

  // Round to nearest, ties up
  always_comb begin
    logic signed [34:0] rb, rd;
    rb     = pb_q + 35'sd32768;
    rd     = pd_q + 35'sd32768;
    step_b = rb[34:16];
    step_d = rd[34:16];
    nb     = brg_q[idx_q] + step_b[15:0];
    nd     = $signed({3'b000, dst_q[idx_q]}) + step_d;
    if (nd < 0)                  nd_sat = 16'd0;
    else if (nd > 19'sd65535)    nd_sat = 16'hFFFF;
    else                         nd_sat = nd[15:0];
    cnf_f    = pc_q[31:16];
    miss_inc = (miss_q[idx_q] == 8'hFF) ? 8'hFF : miss_q[idx_q] + 8'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      r_valid_q   <= 1'b0;
      occ_q       <= '0;
      act_q       <= '0;
      seen_q      <= '0;
      frame_q     <= '0;
      hw_q        <= '0;
      cmd_q       <= '0;
      idx_q       <= '0;
      scan_q      <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      hit_idx_q   <= '0;
      free_idx_q  <= '0;
      known_q     <= 1'b0;
      res_q       <= '0;
      last_slot_q <= 1'b0;
      db_q        <= '0;
      dd_q        <= '0;
      pb_q        <= '0;
      pd_q        <= '0;
      pc_q        <= '0;
      for (int i = 0; i < MaxTargets; i++) begin
        ident_q[i] <= '0;
        miss_q[i]  <= '0;
        brg_q[i]   <= '0;
        dst_q[i]   <= '0;
        conf_q[i]  <= '0;
        col_q[i]   <= '0;
      end
    end else begin
      if (r_valid_q && r_ready_i) r_valid_q <= 1'b0;
      unique case (state_q)
        BkIdle: begin
          if (q_valid_i && !r_valid_q) begin
            cmd_q <= q_cmd_i;
            unique case (q_cmd_i.op)
              OpBegin: begin
                seen_q  <= '0;
                frame_q <= '0;
              end
              OpAdd: begin
                scan_q <= '0;
                hit_q  <= 1'b0;
                free_q <= 1'b0;
                if (frame_q >= CountW'(MaxTargets)) begin
                  res_q   <= make_res(1'b0, StFrameFull, 4'd0, 1'b0, 1'b0, 16'd0,
                                      16'd0, 16'd0, 16'd0, 1'b1);
                  state_q <= BkOut;
                end else begin
                  state_q <= BkSearch;
                end
              end
              OpUpdate: begin
                scan_q <= '0;
                if (hw_q == '0) begin
                  res_q   <= make_res(1'b1, StAccepted, 4'd0, 1'b0, 1'b0, 16'd0,
                                      16'd0, 16'd0, 16'd0, 1'b1);
                  state_q <= BkOut;
                end else begin
                  state_q <= BkUpd;
                end
              end
              OpNone: ;
              default: ;
            endcase
          end
        end
        // Walk slots: first matching hash, first free slot
        BkSearch: begin
          if (occ_q[scan_idx] && ident_q[scan_idx] == cmd_q.hash && !hit_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= scan_idx;
          end
          if (!occ_q[scan_idx] && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= scan_idx;
          end
          scan_q <= scan_q + 1'b1;
          if (scan_q == CountW'(MaxTargets - 1)) state_q <= BkMul;
        end
        BkMul: begin
          if (hit_q) begin
            idx_q   <= hit_idx_q;
            known_q <= 1'b1;
            state_q <= BkWrite;
          end else if (free_q) begin
            idx_q   <= free_idx_q;
            known_q <= 1'b0;
            state_q <= BkWrite;
          end else begin
            res_q   <= make_res(1'b0, StTableFull, 4'd0, 1'b0, 1'b0, 16'd0,
                                16'd0, 16'd0, 16'd0, 1'b1);
            state_q <= BkOut;
          end
          db_q <= '0;
          dd_q <= '0;
        end
        // Sub-steps: register differences, then products, then write
        BkWrite: begin
          state_q <= BkEmit;
          db_q    <= diff_b;
          dd_q    <= diff_d;
        end
        BkEmit: begin
          pb_q    <= $signed({1'b0, cfg_i.gain}) * db_q;
          pd_q    <= $signed({1'b0, cfg_i.gain}) * dd_q;
          state_q <= BkUpdMul;
        end
        BkUpdMul: begin
          if (cmd_q.op == OpAdd) begin
            logic [15:0] rad;
            rad = known_q ? nd_sat : cmd_q.distance;
            if (known_q) begin
              brg_q[idx_q] <= nb;
            end else begin
              brg_q[idx_q]   <= cmd_q.bearing;
              occ_q[idx_q]   <= 1'b1;
              ident_q[idx_q] <= cmd_q.hash;
              if ({1'b0, idx_q} + 1'b1 > hw_q) hw_q <= {1'b0, idx_q} + 1'b1;
            end
            dst_q[idx_q]  <= rad;
            miss_q[idx_q] <= '0;
            act_q[idx_q]  <= cmd_q.confidence >= cfg_i.threshold;
            conf_q[idx_q] <= cmd_q.confidence;
            col_q[idx_q]  <= cmd_q.color;
            seen_q[idx_q] <= 1'b1;
            frame_q       <= frame_q + 1'b1;
            res_q   <= make_res(1'b0, StAccepted, 4'(idx_q), 1'b1,
                                cmd_q.confidence >= cfg_i.threshold, 16'd0, rad,
                                cmd_q.confidence, cmd_q.color, 1'b1);
            state_q <= BkOut;
          end else begin
            // Age one slot, then report it
            logic ev, ac;
            logic [15:0] cf;
            ev = 1'b0;
            ac = act_q[idx_q];
            cf = conf_q[idx_q];
            if (occ_q[idx_q] && !seen_q[idx_q]) begin
              miss_q[idx_q] <= miss_inc;
              if (miss_inc >= cfg_i.miss_limit) begin
                ev = 1'b1;
                ac = 1'b0;
                occ_q[idx_q] <= 1'b0;
                act_q[idx_q] <= 1'b0;
              end else begin
                cf = cnf_f;
                conf_q[idx_q] <= cnf_f;
                if (cnf_f < cfg_i.threshold) begin
                  ac = 1'b0;
                  act_q[idx_q] <= 1'b0;
                end
              end
            end
            res_q   <= make_res(1'b1, StAccepted, 4'(idx_q), 1'b1,
                                occ_q[idx_q] && !ev && ac,
                                brg_q[idx_q] - cmd_q.heading, dst_q[idx_q], cf,
                                col_q[idx_q], last_slot_q);
            state_q <= BkOut;
          end
        end
        // Latch slot index and fade product
        BkUpd: begin
          if (!r_valid_q) begin
            idx_q       <= scan_idx;
            pc_q        <= conf_q[scan_idx] * cfg_i.fade;
            last_slot_q <= (scan_q + 1'b1 == hw_q);
            scan_q      <= scan_q + 1'b1;
            state_q     <= BkUpdMul;
          end
        end
        BkOut: begin
          if (!r_valid_q) begin
            r_valid_q <= 1'b1;
            if (res_q.kind && !res_q.last) state_q <= BkUpd;
            else                           state_q <= BkIdle;
          end
        end
        default: state_q <= BkIdle;
      endcase
    end
  end

endmodule

[sv/ema_target_track_table.sv]
// Top level of the tracked-target table with exponential smoothing.
//
//  channel  dir  handshake            payload
//  s_axis   in   s_tvalid/s_tready    tdata fields, tuser operation
//  m_axis   out  m_tvalid/m_tready    tdata report fields, tuser kind, tlast
//  apb      in   psel/penable/pready  four config registers
//
// An add passes through the hashing of its six address bytes and the queue in
// the front, a pop, a sixteen-slot search, the selection of a slot, registered
// differences, products and write-back, and the output register. An update
// reports the slots in order; the next slot is aged only once the last report
// has been taken. The front takes a new item only once it has queued the last
// one; the back takes a command only when no result waits. Reset clears the
// whole table at once; no clearing pass is needed.
`timescale 1ns / 1ps
module ema_target_track_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [127:0] s_tdata_i,  // mac, bearing, distance, confidence, color, heading
  input  logic [1:0]   s_tuser_i,  // operation
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [71:0]  m_tdata_o,  // status, slot, slot_valid, active, view_angle,
                                   // view_range, confidence_out, color_out
  output logic         m_tuser_o,  // kind
  output logic         m_tlast_o,  // last
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [ettt_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ettt_pkg::*;

  cfg_t cfg_q;
  logic q_valid, q_ready;
  cmd_t q_cmd;
  res_t res;

  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain       <= GainReset;
      cfg_q.miss_limit <= MissLimitReset;
      cfg_q.threshold  <= ThresholdReset;
      cfg_q.fade       <= FadeReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        RegGain:      cfg_q.gain       <= pwdata[15:0];
        RegMissLimit: cfg_q.miss_limit <= pwdata[7:0];
        RegThreshold: cfg_q.threshold  <= pwdata[15:0];
        RegFade:      cfg_q.fade       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr)
      RegGain:      prdata = {16'd0, cfg_q.gain};
      RegMissLimit: prdata = {24'd0, cfg_q.miss_limit};
      RegThreshold: prdata = {16'd0, cfg_q.threshold};
      RegFade:      prdata = {16'd0, cfg_q.fade};
      default:      prdata = '0;
    endcase
  end

  ettt_front u_front (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tdata_i, .s_tuser_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  ettt_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .r_valid_o(m_tvalid_o), .r_ready_i(m_tready_i), .r_res_o(res)
  );

  assign m_tuser_o = res.kind;
  assign m_tlast_o = res.last;
  assign m_tdata_o = {res.color_out, res.confidence_out, res.view_range,
                      res.view_angle, res.active, res.slot_valid, res.slot,
                      res.status};

endmodule

[tb/ema_target_track_table_test.sv]
// Self-checking testbench of the tracked-target table with exponential smoothing.
`timescale 1ns / 1ps
module ema_target_track_table_test;
  import ettt_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [127:0] s_tdata_i = '0;  // mac, bearing, distance, confidence, color, heading
  logic [1:0]   s_tuser_i = OpBegin;  // operation
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  logic [71:0]  m_tdata_o;  // status, slot, slot_valid, active, view_angle,
                            // view_range, confidence_out, color_out
  logic         m_tuser_o;  // kind
  logic         m_tlast_o;  // last
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  ema_target_track_table u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  typedef struct {
    op_e         op;
    logic [47:0] mac;
    logic [15:0] bearing, distance, confidence, color, heading;
  } cmd_s;

  // Model state of the table
  logic [15:0] gain_q, thresh_q, fade_q;
  logic [7:0]  limit_q;
  logic        occ[16], act[16], seen[16];
  logic [31:0] ident[16];
  logic [7:0]  misses[16];
  logic [15:0] brg[16], dst[16], conf[16], col[16];
  int          frame_adds, high_mark;

  res_t        report_q[$];
  int          errors = 0, reports_seen = 0, items_sent = 0;

  function automatic logic [31:0] addr_digest(logic [47:0] mac);
    logic [31:0] h;
    h = 32'd5381;
    for (int b = 0; b < 6; b++) h = ((h << 5) + h) ^ {24'd0, mac[47-8*b -: 8]};
    return (h == 0) ? 32'd1 : h;
  endfunction

  // Round gain*d/65536 to nearest, ties up
  function automatic longint ema_step(logic [15:0] g, longint d);
    longint p;
    p = longint'(g) * d + 32768;
    return p >>> 16;
  endfunction

  function automatic res_t mk(logic k, status_e st, int sl, logic v, logic a,
                              logic [15:0] an, rd, cf, co, logic l);
    res_t r;
    r.kind = k; r.status = st; r.slot = sl[3:0]; r.slot_valid = v; r.active = a;
    r.view_angle = an; r.view_range = rd; r.confidence_out = cf;
    r.color_out = co; r.last = l;
    return r;
  endfunction

  task automatic predict_table(cmd_s c);
    logic [31:0] h;
    int idx;
    longint d, nb, nd;
    if (c.op == OpBegin) begin
      foreach (seen[i]) seen[i] = 1'b0;
      frame_adds = 0;
    end else if (c.op == OpAdd) begin
      idx = -1;
      if (frame_adds >= 16) begin
        report_q.push_back(mk(0, StFrameFull, 0, 0, 0, 0, 0, 0, 0, 1));
        return;
      end
      h = addr_digest(c.mac);
      for (int i = 0; i < 16; i++) if (idx < 0 && occ[i] && ident[i] == h) idx = i;
      if (idx < 0) begin
        for (int i = 0; i < 16; i++) if (idx < 0 && !occ[i]) idx = i;
        if (idx < 0) begin
          report_q.push_back(mk(0, StTableFull, 0, 0, 0, 0, 0, 0, 0, 1));
          return;
        end
        occ[idx] = 1'b1;
        if (idx + 1 > high_mark) high_mark = idx + 1;
        ident[idx] = h; brg[idx] = c.bearing; dst[idx] = c.distance;
      end else begin
        d = longint'(c.bearing) - longint'(brg[idx]);
        if (d > 32768) d -= 65536;
        if (d < -32768) d += 65536;
        nb = longint'(brg[idx]) + ema_step(gain_q, d);
        brg[idx] = nb[15:0];
        nd = longint'(dst[idx]) + ema_step(gain_q, longint'(c.distance) - longint'(dst[idx]));
        if (nd < 0) nd = 0;
        if (nd > 65535) nd = 65535;
        dst[idx] = nd[15:0];
      end
      misses[idx] = 0; act[idx] = c.confidence >= thresh_q;
      conf[idx] = c.confidence; col[idx] = c.color; seen[idx] = 1'b1;
      frame_adds++;
      report_q.push_back(mk(0, StAccepted, idx, 1, act[idx], 0, dst[idx],
                            c.confidence, c.color, 1));
    end else if (c.op == OpUpdate) begin
      if (high_mark == 0) begin
        report_q.push_back(mk(1, StAccepted, 0, 0, 0, 0, 0, 0, 0, 1));
        return;
      end
      for (int i = 0; i < high_mark; i++) begin
        if (occ[i] && !seen[i]) begin
          if (misses[i] < 255) misses[i]++;
          if (misses[i] >= limit_q) begin
            occ[i] = 1'b0; act[i] = 1'b0;
          end else begin
            conf[i] = 16'((32'(conf[i]) * 32'(fade_q)) >> 16);
            if (conf[i] < thresh_q) act[i] = 1'b0;
          end
        end
        report_q.push_back(mk(1, StAccepted, i, 1, occ[i] && act[i],
                              brg[i] - c.heading, dst[i], conf[i], col[i],
                              i + 1 == high_mark));
      end
    end
  endtask

  // Compare each transfer on the result side with the oldest prediction
  always @(posedge clk_i) begin
    res_t g, e;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      g = mk(m_tuser_o, status_e'(m_tdata_o[1:0]), m_tdata_o[5:2], m_tdata_o[6],
             m_tdata_o[7], m_tdata_o[23:8], m_tdata_o[39:24], m_tdata_o[55:40],
             m_tdata_o[71:56], m_tlast_o);
      reports_seen++;
      if (report_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = report_q.pop_front();
        if (g.kind != e.kind) begin $error("kind exp %0d got %0d", e.kind, g.kind); errors++; end
        if (g.status != e.status) begin
          $error("status exp %0d got %0d", e.status, g.status); errors++;
        end
        if (g.slot != e.slot) begin $error("slot exp %0d got %0d", e.slot, g.slot); errors++; end
        if (g.slot_valid != e.slot_valid) begin
          $error("slot_valid exp %0d got %0d", e.slot_valid, g.slot_valid); errors++;
        end
        if (g.active != e.active) begin
          $error("active exp %0d got %0d", e.active, g.active); errors++;
        end
        if (g.view_angle != e.view_angle) begin
          $error("view_angle exp %0d got %0d", e.view_angle, g.view_angle); errors++;
        end
        if (g.view_range != e.view_range) begin
          $error("view_range exp %0d got %0d", e.view_range, g.view_range); errors++;
        end
        if (g.confidence_out != e.confidence_out) begin
          $error("confidence_out exp %0d got %0d", e.confidence_out, g.confidence_out);
          errors++;
        end
        if (g.color_out != e.color_out) begin
          $error("color_out exp %0d got %0d", e.color_out, g.color_out); errors++;
        end
        if (g.last != e.last) begin $error("last exp %0d got %0d", e.last, g.last); errors++; end
      end
    end
  end

  // Receiver stalls on its own pattern, with stall-free stretches
  int stall_mode = 0;
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready_i <= 1'b1;
      1: m_tready_i <= (r % 3) != 0;
      default: m_tready_i <= r < 25;
    endcase
  end

  task automatic write_reg(logic [CfgAddrW-1:0] a, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (a)
      RegGain:      gain_q = v[15:0];
      RegMissLimit: limit_q = v[7:0];
      RegThreshold: thresh_q = v[15:0];
      default:      fade_q = v[15:0];
    endcase
  endtask

  int gap_left = 0;
  // Drive one item, hold it until accepted; sender gaps come in bursts
  task automatic send_cmd(cmd_s c);
    if (gap_left > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap_left) @(posedge clk_i);
      gap_left = 0;
    end
    s_tvalid_i <= 1'b1; s_tuser_i <= c.op;
    s_tdata_i <= {c.heading, c.color, c.confidence, c.distance, c.bearing, c.mac};
    predict_table(c);
    do @(posedge clk_i); while (!s_tready_o);
    items_sent++;
    if ($urandom_range(0, 5) == 0) begin
      gap_left = $urandom_range(1, 30);
      s_tvalid_i <= 1'b0;
    end
  endtask

  task automatic drain(int lat);
    int guard;
    guard = 0;
    s_tvalid_i <= 1'b0;
    while (report_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (lat) @(posedge clk_i);
  endtask

  function automatic cmd_s rand_cmd(int pool);
    cmd_s c;
    int r;
    r = $urandom_range(0, 99);
    c.op = r < 65 ? OpAdd : (r < 80 ? OpUpdate : (r < 96 ? OpBegin : OpNone));
    c.mac = (pool > 0) ? 48'($urandom_range(1, pool)) * 48'h0101_0203_0405
                       : {16'($urandom), 32'($urandom)};
    c.bearing = 16'($urandom); c.distance = 16'($urandom);
    c.confidence = 16'($urandom); c.color = 16'($urandom); c.heading = 16'($urandom);
    return c;
  endfunction

  // Directed rows: op, mac, bearing, distance, confidence, color, heading
  cmd_s dir_tab[$];

  initial begin
    cmd_s c;
    res_t hold[$];
    gain_q = GainReset; limit_q = MissLimitReset; thresh_q = ThresholdReset;
    fade_q = FadeReset;
    foreach (occ[i]) begin
      occ[i] = 0; act[i] = 0; seen[i] = 0; ident[i] = 0; misses[i] = 0;
      brg[i] = 0; dst[i] = 0; conf[i] = 0; col[i] = 0;
    end
    frame_adds = 0; high_mark = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty update, extremes, wrap of the bearing, full table, full frame
    dir_tab.push_back('{OpUpdate, 48'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF});
    dir_tab.push_back('{OpNone, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'hFFFF});
    dir_tab.push_back('{OpBegin, 48'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
    dir_tab.push_back('{OpAdd, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'hFFFF, 16'h0});
    dir_tab.push_back('{OpAdd, 48'hFFFF_FFFF_FFFF, 16'h0001, 16'h0, 16'h0, 16'h5555, 16'h0});
    dir_tab.push_back('{OpAdd, 48'h0, 16'h8000, 16'h1234, 16'h8000, 16'hAAAA, 16'h0});
    dir_tab.push_back('{OpAdd, 48'h0, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h0F0F, 16'h0});
    dir_tab.push_back('{OpUpdate, 48'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h8000});
    dir_tab.push_back('{OpBegin, 48'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
    dir_tab.push_back('{OpUpdate, 48'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h1234});
    for (int i = 0; i < 15; i++)
      dir_tab.push_back('{OpAdd, 48'h1000 + 48'(i), 16'(i * 4000), 16'(i * 300), 16'hC000,
                          16'(i), 16'h0});
    // Repeat a known address until the frame runs out of adds
    for (int i = 0; i < 3; i++)
      dir_tab.push_back('{OpAdd, 48'h1000, 16'h4000, 16'h2000, 16'h9000, 16'h1111, 16'h0});
    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == OpUpdate && i == 0)
        hold = '{mk(1, StAccepted, 0, 0, 0, 0, 0, 0, 0, 1)};
      else hold = '{};
      send_cmd(dir_tab[i]);
      // Empty-table report is typed in; check it agrees with the prediction
      if (hold.size() != 0 && report_q.size() != 0 && report_q[$] != hold[0]) begin
        $error("empty-table report mismatch"); errors++;
      end
    end
    drain(80);

    // Random phases across register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(RegGain, 0); write_reg(RegMissLimit, 1);
                 write_reg(RegThreshold, 32'hFFFF); write_reg(RegFade, 0); end
        1: begin write_reg(RegGain, 32'hFFFF); write_reg(RegMissLimit, 255);
                 write_reg(RegThreshold, 0); write_reg(RegFade, 32'hFFFF); end
        2: begin write_reg(RegGain, 0); write_reg(RegMissLimit, 0); end
        default: begin write_reg(RegGain, $urandom); write_reg(RegMissLimit,
                         $urandom_range(1, 6)); write_reg(RegThreshold, $urandom);
                       write_reg(RegFade, $urandom); end
      endcase
      for (int n = 0; n < 65; n++) begin
        c = rand_cmd(ph == 4 ? 0 : $urandom_range(4, 24));
        send_cmd(c);
      end
      drain(80);
    end

    $display("Sent %0d items over 7 phases; checked %0d results.", items_sent, reports_seen);
    if (errors == 0 && report_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

[sim.f]
sv/ettt_pkg.sv
sv/ettt_front.sv
sv/ettt_back.sv
sv/ema_target_track_table.sv
tb/ema_target_track_table_test.sv
